// ===== sv/indexed_doubly_linked_list_assert.svh =====
`ifndef INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define IDLL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IDLL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/idll_pkg.sv =====
package idll_pkg;

    localparam int MAX_NODES_DEF = 1024;

    typedef enum logic [1:0] {
        CMD_INS_BEFORE = 2'd0,
        CMD_INS_AFTER  = 2'd1,
        CMD_REMOVE     = 2'd2,
        CMD_READ       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_EXHAUSTED = 3'd1,
        STAT_ABSENT    = 3'd2,
        STAT_IGNORED   = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

endpackage

// ===== sv/idll_ram.sv =====
module idll_ram #(
    parameter int DATA_W = 11,
    parameter int DEPTH  = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/idll_ctrl.sv =====
module idll_ctrl #(
    parameter int MAX_NODES = idll_pkg::MAX_NODES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [$clog2(MAX_NODES+1)-1:0] anchor_id,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [$clog2(MAX_NODES+1)-1:0] node_id,
    output logic                           last,
    output logic                           rd_en,
    output logic [$clog2(MAX_NODES+1)-1:0] rd_addr,
    output logic                           prev_we,
    output logic [$clog2(MAX_NODES+1)-1:0] prev_waddr,
    output logic [$clog2(MAX_NODES+1)-1:0] prev_wdata,
    input  logic [$clog2(MAX_NODES+1)-1:0] prev_rdata,
    output logic                           next_we,
    output logic [$clog2(MAX_NODES+1)-1:0] next_waddr,
    output logic [$clog2(MAX_NODES+1)-1:0] next_wdata,
    input  logic [$clog2(MAX_NODES+1)-1:0] next_rdata,
    output logic                           mark_we,
    output logic [$clog2(MAX_NODES+1)-1:0] mark_waddr,
    output logic                           mark_wdata,
    input  logic                           mark_rdata
);

    localparam int ID_W  = $clog2(MAX_NODES + 1);
    // id counter must also hold MAX_NODES + 1
    localparam int CNT_W = $clog2(MAX_NODES + 2);
    localparam logic [ID_W-1:0]  ID_NONE = '0;
    localparam logic [ID_W-1:0]  ID_ONE  = ID_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] ID_MAX  = CNT_W'(MAX_NODES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LINK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    idll_pkg::cmd_t       cmd_reg;
    logic [ID_W-1:0]      anchor_reg;
    logic [ID_W-1:0]      head_reg, head_next;
    logic [ID_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]     next_new_reg, next_new_next;
    logic [ID_W-1:0]      live_reg, live_next;
    logic [ID_W-1:0]      cursor_reg, cursor_next;
    logic [ID_W-1:0]      nbr_reg, nbr_next;
    idll_pkg::status_t    res_status_reg, res_status_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic                 res_last_reg, res_last_next;
    logic                 out_valid_reg, out_valid_next;
    idll_pkg::status_t    status_reg;
    logic [ID_W-1:0]      node_id_reg;
    logic                 last_reg;

    logic                 accept;
    logic                 out_free;
    logic                 anchor_live;
    logic [ID_W-1:0]      read_id;
    logic [ID_W-1:0]      new_id;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign rd_en    = accept;
    assign rd_addr  = (idll_pkg::cmd_t'(cmd) == idll_pkg::CMD_READ) ? cursor_reg : anchor_id;
    assign out_free = !out_valid_reg || !out_stall;
    assign new_id   = ID_W'(next_new_reg);

    assign anchor_live = (anchor_reg != ID_NONE) && (CNT_W'(anchor_reg) < next_new_reg)
                         && !mark_rdata;

    always_comb
    begin
        read_id = (cursor_reg == ID_NONE) ? head_reg : next_rdata;
        if (read_id == ID_NONE)
        begin
            read_id = head_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        next_new_next   = next_new_reg;
        live_next       = live_reg;
        cursor_next     = cursor_reg;
        nbr_next        = nbr_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_last_next   = res_last_reg;
        prev_we         = 1'b0;
        prev_waddr      = new_id;
        prev_wdata      = ID_NONE;
        next_we         = 1'b0;
        next_waddr      = new_id;
        next_wdata      = ID_NONE;
        mark_we         = 1'b0;
        mark_waddr      = new_id;
        mark_wdata      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next    = S_DONE;
                res_status_next = idll_pkg::STAT_OK;
                res_id_next   = ID_NONE;
                res_last_next = 1'b0;
                case (cmd_reg)
                    idll_pkg::CMD_INS_BEFORE, idll_pkg::CMD_INS_AFTER:
                    begin
                        if (next_new_reg > ID_MAX)
                        begin
                            res_status_next = idll_pkg::STAT_EXHAUSTED;
                        end
                        else if (live_reg == ID_NONE)
                        begin
                            prev_we       = 1'b1;
                            next_we       = 1'b1;
                            mark_we       = 1'b1;
                            head_next     = new_id;
                            tail_next     = new_id;
                            next_new_next = next_new_reg + CNT_ONE;
                            live_next     = live_reg + ID_ONE;
                            res_id_next   = new_id;
                        end
                        else if (!anchor_live)
                        begin
                            res_status_next = idll_pkg::STAT_ABSENT;
                        end
                        else
                        begin
                            prev_we    = 1'b1;
                            next_we    = 1'b1;
                            mark_we    = 1'b1;
                            state_next = S_LINK;
                            if (cmd_reg == idll_pkg::CMD_INS_BEFORE)
                            begin
                                prev_wdata = prev_rdata;
                                next_wdata = anchor_reg;
                                nbr_next   = prev_rdata;
                            end
                            else
                            begin
                                prev_wdata = anchor_reg;
                                next_wdata = next_rdata;
                                nbr_next   = next_rdata;
                            end
                        end
                    end
                    idll_pkg::CMD_REMOVE:
                    begin
                        if (!anchor_live)
                        begin
                            res_status_next = idll_pkg::STAT_IGNORED;
                        end
                        else
                        begin
                            if (prev_rdata != ID_NONE)
                            begin
                                next_we    = 1'b1;
                                next_waddr = prev_rdata;
                                next_wdata = next_rdata;
                            end
                            else
                            begin
                                head_next = next_rdata;
                            end
                            if (next_rdata != ID_NONE)
                            begin
                                prev_we    = 1'b1;
                                prev_waddr = next_rdata;
                                prev_wdata = prev_rdata;
                            end
                            else
                            begin
                                tail_next = prev_rdata;
                            end
                            if (cursor_reg == anchor_reg)
                            begin
                                cursor_next = prev_rdata;
                            end
                            mark_we    = 1'b1;
                            mark_waddr = anchor_reg;
                            mark_wdata = 1'b1;
                            live_next  = live_reg - ID_ONE;
                        end
                    end
                    idll_pkg::CMD_READ:
                    begin
                        if (live_reg == ID_NONE)
                        begin
                            cursor_next     = ID_NONE;
                            res_status_next = idll_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            res_id_next = read_id;
                            if (read_id == tail_reg)
                            begin
                                cursor_next   = ID_NONE;
                                res_last_next = 1'b1;
                            end
                            else
                            begin
                                cursor_next = read_id;
                            end
                        end
                    end
                    default:
                    begin
                        res_status_next = idll_pkg::STAT_IGNORED;
                    end
                endcase
            end
            S_LINK:
            begin
                state_next = S_DONE;
                if (cmd_reg == idll_pkg::CMD_INS_BEFORE)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = anchor_reg;
                    prev_wdata = new_id;
                    if (nbr_reg != ID_NONE)
                    begin
                        next_we    = 1'b1;
                        next_waddr = nbr_reg;
                        next_wdata = new_id;
                    end
                    else
                    begin
                        head_next = new_id;
                    end
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = anchor_reg;
                    next_wdata = new_id;
                    if (nbr_reg != ID_NONE)
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = nbr_reg;
                        prev_wdata = new_id;
                    end
                    else
                    begin
                        tail_next = new_id;
                    end
                end
                next_new_next   = next_new_reg + CNT_ONE;
                live_next       = live_reg + ID_ONE;
                res_status_next = idll_pkg::STAT_OK;
                res_id_next     = new_id;
                res_last_next   = 1'b0;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= ID_NONE;
            tail_reg      <= ID_NONE;
            next_new_reg  <= CNT_ONE;
            live_reg      <= ID_NONE;
            cursor_reg    <= ID_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            next_new_reg  <= next_new_next;
            live_reg      <= live_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= idll_pkg::cmd_t'(cmd);
            anchor_reg <= anchor_id;
        end
        nbr_reg        <= nbr_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_last_reg   <= res_last_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            status_reg  <= res_status_reg;
            node_id_reg <= res_id_reg;
            last_reg    <= res_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign node_id   = node_id_reg;
    assign last      = last_reg;

`include "indexed_doubly_linked_list_assert.svh"

    `IDLL_ASSERT_IMP(a_live_bound, 1'b1, CNT_W'(live_reg) < next_new_reg, "live count exceeds ids")
    `IDLL_ASSERT_IMP(a_empty_ends, live_reg == ID_NONE, {head_reg, tail_reg} == '0, "empty list ends")
    `IDLL_ASSERT_IMP(a_cursor_live, cursor_reg != ID_NONE, live_reg != ID_NONE, "cursor on empty list")
    `IDLL_ASSERT_NXT(a_accept_read, accept, state_reg == S_READ, "accepted transaction not read")

endmodule

// ===== sv/indexed_doubly_linked_list.sv =====
// Array-backed doubly linked list of node ids. Each transaction carries one command
// (insert before, insert after, remove, read next) and returns one result. Ids are
// handed out in order from 1 up to MAX_NODES. One transaction is handled at a time:
// remove, read, failed inserts and inserts into an empty list use S_READ and S_DONE;
// a successful insert into a non-empty list adds S_LINK, as the previous and next
// link tables each have a single write port and an insert may write each twice. The
// result sits in an output register, so the next transaction is accepted while it
// waits; no clearing pass runs after reset; link tables are read only where written.
module indexed_doubly_linked_list #(
    parameter int MAX_NODES = idll_pkg::MAX_NODES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [$clog2(MAX_NODES+1)-1:0] anchor_id,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [$clog2(MAX_NODES+1)-1:0] node_id,
    output logic                           last
);

    localparam int ID_W  = $clog2(MAX_NODES + 1);
    localparam int DEPTH = MAX_NODES + 1;

    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
    logic            prev_we, next_we, mark_we;
    logic [ID_W-1:0] prev_waddr, next_waddr, mark_waddr;
    logic [ID_W-1:0] prev_wdata, next_wdata;
    logic            mark_wdata;
    logic [ID_W-1:0] prev_rdata, next_rdata;
    logic            mark_rdata;

    idll_ctrl #(
        .MAX_NODES(MAX_NODES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .anchor_id (anchor_id),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .node_id   (node_id),
        .last      (last),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .prev_we   (prev_we),
        .prev_waddr(prev_waddr),
        .prev_wdata(prev_wdata),
        .prev_rdata(prev_rdata),
        .next_we   (next_we),
        .next_waddr(next_waddr),
        .next_wdata(next_wdata),
        .next_rdata(next_rdata),
        .mark_we   (mark_we),
        .mark_waddr(mark_waddr),
        .mark_wdata(mark_wdata),
        .mark_rdata(mark_rdata)
    );

    idll_ram #(
        .DATA_W(ID_W),
        .DEPTH (DEPTH)
    ) u_prev_ram (
        .clk  (clk),
        .we   (prev_we),
        .waddr(prev_waddr),
        .wdata(prev_wdata),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(prev_rdata)
    );

    idll_ram #(
        .DATA_W(ID_W),
        .DEPTH (DEPTH)
    ) u_next_ram (
        .clk  (clk),
        .we   (next_we),
        .waddr(next_waddr),
        .wdata(next_wdata),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(next_rdata)
    );

    idll_ram #(
        .DATA_W(1),
        .DEPTH (DEPTH)
    ) u_mark_ram (
        .clk  (clk),
        .we   (mark_we),
        .waddr(mark_waddr),
        .wdata(mark_wdata),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(mark_rdata)
    );

endmodule
